>>> rtl/mfde_pkg.sv
// Shared constants and types for the monochrome framebuffer draw engine.
package mfde_pkg;

  localparam int PANEL_WIDTH  = 128;
  localparam int PANEL_HEIGHT = 64;
  localparam int STORE_BYTES  = PANEL_WIDTH * ((PANEL_HEIGHT + 7) / 8);
  localparam int ADDR_W       = $clog2(STORE_BYTES);

  localparam logic [7:0] FILL_WHITE = 8'hFF;
  localparam logic [7:0] FILL_BLACK = 8'h00;

  typedef enum logic [2:0] {
    OP_CLEAR      = 3'd0,
    OP_PIXEL      = 3'd1,
    OP_READ       = 3'd2,
    OP_LINE       = 3'd3,
    OP_RECT       = 3'd4,
    OP_FILL_RECT  = 3'd5,
    OP_CIRCLE     = 3'd6,
    OP_FILL_CIRC  = 3'd7
  } op_e;

endpackage

>>> rtl/mfde_ram.sv
// Generic simple dual-port RAM with a registered read.
module mfde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> rtl/mono_framebuffer_draw_engine.sv
// Monochrome framebuffer draw engine: one drawing command per request, rasterized by a small
// sequencer one pixel at a time. Every in-bounds pixel is a read-modify-write of the frame
// memory: a read in S_PLOT and the write in S_PLOT_WR, after the step that generates the
// pixel; a clipped pixel skips both. A clear writes one byte per cycle over all STORE_BYTES
// bytes (1024 at 128x64). After reset the engine runs the same pass over the memory before
// it takes a request. A read returns its pixel, or 0 when out of bounds; every other command
// returns 0 once it has finished.
module mono_framebuffer_draw_engine
  import mfde_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] op_i,
  input  logic [7:0] x_a_i,
  input  logic [7:0] y_a_i,
  input  logic [7:0] x_b_i,
  input  logic [7:0] y_b_i,
  input  logic       color_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       pixel_value_o,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i
);

  localparam logic [3:0] S_INIT     = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_CLR      = 4'd2;
  localparam logic [3:0] S_PLOT     = 4'd3;
  localparam logic [3:0] S_PLOT_WR  = 4'd4;
  localparam logic [3:0] S_READ     = 4'd5;
  localparam logic [3:0] S_READ_WT  = 4'd6;
  localparam logic [3:0] S_LINE     = 4'd7;
  localparam logic [3:0] S_RECT     = 4'd8;
  localparam logic [3:0] S_SPAN     = 4'd9;
  localparam logic [3:0] S_CIRC_INI = 4'd10;
  localparam logic [3:0] S_CIRC_PLT = 4'd11;
  localparam logic [3:0] S_CIRC_STP = 4'd12;
  localparam logic [3:0] S_CIRC_END = 4'd13;
  localparam logic [3:0] S_DONE     = 4'd14;

  logic [3:0] state_q, state_d, ret_q, ret_d;
  logic       inv_q, inv_d;
  op_e        op_q, op_d;
  logic       col_q, col_d;
  logic [7:0] xa_q, xa_d, ya_q, ya_d, xb_q, xb_d, yb_q, yb_d;
  logic [7:0] plot_x_q, plot_x_d, plot_y_q, plot_y_d;
  logic [ADDR_W-1:0] wr_addr_q, wr_addr_d;
  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;
  logic [7:0] clr_fill_q, clr_fill_d;
  // Line walker.
  logic [7:0] lx_q, lx_d, ly_q, ly_d, ldx_q, ldx_d, ldy_q, ldy_d;
  logic       lsx_q, lsx_d, lsy_q, lsy_d;
  logic signed [10:0] lerr_q, lerr_d;
  // Span walker and rectangle sequencing.
  logic [8:0] sp_cnt_q, sp_cnt_d, sp_hi_q, sp_hi_d, seg_q, seg_d;
  logic [7:0] sp_fix_q, sp_fix_d, xe_q, xe_d, ye_q, ye_d;
  logic       sp_horiz_q, sp_horiz_d;
  // Circle walker.
  logic [7:0] rad_q, rad_d, cpx_q, cpx_d, cpy_q, cpy_d;
  logic signed [12:0] cf_q, cf_d, cddx_q, cddx_d, cddy_q, cddy_d;
  logic [2:0] k_q, k_d;
  logic       out_valid_q, out_valid_d, pixel_q, pixel_d, res_q, res_d;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata, ram_rdata;
  logic              in_bounds;
  logic [ADDR_W-1:0] plot_addr;
  logic [7:0]        bit_mask;
  logic [7:0]        dx_in, dy_in, span_a, span_b;
  logic signed [11:0] e2;
  logic               step_x, step_y;
  logic signed [12:0] f_bump;

  assign in_bounds = ({1'b0, plot_x_q} < 9'(PANEL_WIDTH)) &&
                     ({1'b0, plot_y_q} < 9'(PANEL_HEIGHT));
  assign plot_addr = ADDR_W'(plot_x_q) + ADDR_W'(plot_y_q >> 3) * ADDR_W'(PANEL_WIDTH);
  assign bit_mask  = 8'(1) << plot_y_q[2:0];
  assign dx_in     = (x_b_i > x_a_i) ? (x_b_i - x_a_i) : (x_a_i - x_b_i);
  assign dy_in     = (y_b_i > y_a_i) ? (y_b_i - y_a_i) : (y_a_i - y_b_i);
  assign e2        = {lerr_q[10], lerr_q} <<< 1;
  assign step_x    = e2 > -$signed({4'b0, ldy_q});
  assign step_y    = e2 < $signed({4'b0, ldx_q});
  assign f_bump    = (cf_q >= 0) ? (cddy_q + 13'sd2) : 13'sd0;

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign pixel_value_o = pixel_q;

  always_comb begin
    state_d = state_q;    ret_d = ret_q;       inv_d = inv_q;
    op_d = op_q;          col_d = col_q;
    xa_d = xa_q; ya_d = ya_q; xb_d = xb_q; yb_d = yb_q;
    plot_x_d = plot_x_q;  plot_y_d = plot_y_q; wr_addr_d = wr_addr_q;
    clr_cnt_d = clr_cnt_q; clr_fill_d = clr_fill_q;
    lx_d = lx_q; ly_d = ly_q; ldx_d = ldx_q; ldy_d = ldy_q;
    lsx_d = lsx_q; lsy_d = lsy_q; lerr_d = lerr_q;
    sp_cnt_d = sp_cnt_q; sp_hi_d = sp_hi_q; seg_d = seg_q;
    sp_fix_d = sp_fix_q; xe_d = xe_q; ye_d = ye_q; sp_horiz_d = sp_horiz_q;
    rad_d = rad_q; cpx_d = cpx_q; cpy_d = cpy_q;
    cf_d = cf_q; cddx_d = cddx_q; cddy_d = cddy_q; k_d = k_q;
    out_valid_d = out_valid_q; pixel_d = pixel_q; res_d = res_q;
    ram_we = 1'b0; ram_re = 1'b0; ram_waddr = wr_addr_q; ram_wdata = ram_rdata;
    span_a = 8'd0; span_b = 8'd0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cfg_we_i) begin
      inv_d = cfg_wdata_i;
    end

    unique case (state_q)
      S_INIT, S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = clr_fill_q;
        clr_cnt_d = clr_cnt_q + ADDR_W'(1);
        if (clr_cnt_q == ADDR_W'(STORE_BYTES - 1)) begin
          state_d = (state_q == S_INIT) ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_d = op_e'(op_i);
          col_d = color_i ^ inv_q;
          xa_d = x_a_i; ya_d = y_a_i; xb_d = x_b_i; yb_d = y_b_i;
          plot_x_d = x_a_i; plot_y_d = y_a_i;
          res_d = 1'b0;
          ret_d = S_DONE;
          xe_d = x_a_i + x_b_i - 8'd1;
          ye_d = y_a_i + y_b_i - 8'd1;
          seg_d = 9'd0;
          unique case (op_e'(op_i))
            OP_CLEAR: begin
              clr_cnt_d  = '0;
              clr_fill_d = color_i ? FILL_WHITE : FILL_BLACK;
              state_d    = S_CLR;
            end
            OP_PIXEL: state_d = S_PLOT;
            OP_READ:  state_d = S_READ;
            OP_LINE: begin
              lx_d = x_a_i; ly_d = y_a_i; ldx_d = dx_in; ldy_d = dy_in;
              lsx_d = x_a_i < x_b_i; lsy_d = y_a_i < y_b_i;
              lerr_d = $signed({3'b0, dx_in}) - $signed({3'b0, dy_in});
              state_d = S_LINE;
            end
            OP_RECT, OP_FILL_RECT: begin
              state_d = (x_b_i == 8'd0 || y_b_i == 8'd0) ? S_DONE : S_RECT;
            end
            OP_CIRCLE: begin
              rad_d = x_b_i;
              state_d = S_CIRC_INI;
            end
            OP_FILL_CIRC: begin
              rad_d = 8'd0;
              state_d = S_CIRC_INI;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_PLOT: begin
        wr_addr_d = plot_addr;
        if (in_bounds) begin
          ram_re  = 1'b1;
          state_d = S_PLOT_WR;
        end else begin
          state_d = ret_q;
        end
      end
      S_PLOT_WR: begin
        ram_we    = 1'b1;
        ram_wdata = col_q ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
        state_d   = ret_q;
      end
      S_READ: begin
        if (in_bounds) begin
          ram_re  = 1'b1;
          state_d = S_READ_WT;
        end else begin
          state_d = S_DONE;
        end
      end
      S_READ_WT: begin
        res_d   = ((ram_rdata & bit_mask) != 8'd0) ^ inv_q;
        state_d = S_DONE;
      end
      S_LINE: begin
        plot_x_d = lx_q;
        plot_y_d = ly_q;
        ret_d    = (lx_q == xb_q && ly_q == yb_q) ? S_DONE : S_LINE;
        lerr_d   = lerr_q - (step_x ? $signed({3'b0, ldy_q}) : 11'sd0)
                          + (step_y ? $signed({3'b0, ldx_q}) : 11'sd0);
        if (step_x) lx_d = lsx_q ? lx_q + 8'd1 : lx_q - 8'd1;
        if (step_y) ly_d = lsy_q ? ly_q + 8'd1 : ly_q - 8'd1;
        state_d = S_PLOT;
      end
      S_RECT: begin
        // Outline: two rows then two columns. Fill: one row per pass.
        priority if (op_q == OP_RECT && seg_q < 9'd4) begin
          sp_horiz_d = ~seg_q[1];
          span_a     = seg_q[1] ? ya_q : xa_q;
          span_b     = seg_q[1] ? ye_q : xe_q;
          unique case (seg_q[1:0])
            2'd0:    sp_fix_d = ya_q;
            2'd1:    sp_fix_d = ye_q;
            2'd2:    sp_fix_d = xa_q;
            default: sp_fix_d = xe_q;
          endcase
          state_d = S_SPAN;
        end else if (op_q == OP_FILL_RECT && seg_q < {1'b0, yb_q}) begin
          sp_horiz_d = 1'b1;
          span_a     = xa_q;
          span_b     = xe_q;
          sp_fix_d   = ya_q + seg_q[7:0];
          state_d    = S_SPAN;
        end else begin
          state_d = S_DONE;
        end
        sp_cnt_d = {1'b0, (span_a < span_b) ? span_a : span_b};
        sp_hi_d  = {1'b0, (span_a < span_b) ? span_b : span_a};
        seg_d    = seg_q + 9'd1;
      end
      S_SPAN: begin
        plot_x_d = sp_horiz_q ? sp_cnt_q[7:0] : sp_fix_q;
        plot_y_d = sp_horiz_q ? sp_fix_q : sp_cnt_q[7:0];
        ret_d    = (sp_cnt_q == sp_hi_q) ? S_RECT : S_SPAN;
        sp_cnt_d = sp_cnt_q + 9'd1;
        state_d  = S_PLOT;
      end
      S_CIRC_INI: begin
        cf_d   = 13'sd1 - $signed({5'b0, rad_q});
        cddx_d = 13'sd1;
        cddy_d = -$signed({4'b0, rad_q, 1'b0});
        cpx_d  = 8'd0;
        cpy_d  = rad_q;
        k_d    = 3'd0;
        state_d = S_CIRC_PLT;
      end
      S_CIRC_PLT: begin
        // The first pass with px = 0 also covers the four axis points.
        plot_x_d = k_q[2] ? (k_q[0] ? xa_q - cpy_q : xa_q + cpy_q)
                          : (k_q[0] ? xa_q - cpx_q : xa_q + cpx_q);
        plot_y_d = k_q[2] ? (k_q[1] ? ya_q - cpx_q : ya_q + cpx_q)
                          : (k_q[1] ? ya_q - cpy_q : ya_q + cpy_q);
        k_d = k_q + 3'd1;
        if (k_q == 3'd7) begin
          ret_d = (cpx_q < cpy_q) ? S_CIRC_STP : S_CIRC_END;
        end else begin
          ret_d = S_CIRC_PLT;
        end
        state_d = S_PLOT;
      end
      S_CIRC_STP: begin
        if (cf_q >= 0) begin
          cpy_d  = cpy_q - 8'd1;
          cddy_d = cddy_q + 13'sd2;
        end
        cpx_d   = cpx_q + 8'd1;
        cddx_d  = cddx_q + 13'sd2;
        cf_d    = cf_q + f_bump + cddx_q + 13'sd2;
        k_d     = 3'd0;
        state_d = S_CIRC_PLT;
      end
      S_CIRC_END: begin
        if (op_q == OP_FILL_CIRC && rad_q < xb_q) begin
          rad_d   = rad_q + 8'd1;
          state_d = S_CIRC_INI;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          pixel_d     = res_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      clr_cnt_q   <= '0;
      clr_fill_q  <= FILL_BLACK;
      inv_q       <= 1'b0;
      out_valid_q <= 1'b0;
      ret_q       <= S_IDLE;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      clr_fill_q  <= clr_fill_d;
      inv_q       <= inv_d;
      out_valid_q <= out_valid_d;
      ret_q       <= ret_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; col_q <= col_d;
    xa_q <= xa_d; ya_q <= ya_d; xb_q <= xb_d; yb_q <= yb_d;
    plot_x_q <= plot_x_d; plot_y_q <= plot_y_d; wr_addr_q <= wr_addr_d;
    lx_q <= lx_d; ly_q <= ly_d; ldx_q <= ldx_d; ldy_q <= ldy_d;
    lsx_q <= lsx_d; lsy_q <= lsy_d; lerr_q <= lerr_d;
    sp_cnt_q <= sp_cnt_d; sp_hi_q <= sp_hi_d; seg_q <= seg_d;
    sp_fix_q <= sp_fix_d; xe_q <= xe_d; ye_q <= ye_d; sp_horiz_q <= sp_horiz_d;
    rad_q <= rad_d; cpx_q <= cpx_d; cpy_q <= cpy_d;
    cf_q <= cf_d; cddx_q <= cddx_d; cddy_q <= cddy_d; k_q <= k_d;
    pixel_q <= pixel_d; res_q <= res_d;
  end

  mfde_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (plot_addr),
    .rdata_o (ram_rdata)
  );

endmodule
